[design/tiled_exclusion_mask_lookup_defines.svh]
// Assertion macros for the tiled exclusion mask lookup.
// Included by the top level; needs no other file.
`ifndef TILED_EXCLUSION_MASK_LOOKUP_DEFINES_SVH
`define TILED_EXCLUSION_MASK_LOOKUP_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define TEMLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the cycle after its trigger
`define TEMLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/temlu_pkg.sv]
// Shared types and constants for the tiled exclusion mask lookup.
// No dependencies.
`timescale 1ns / 1ps

package temlu_pkg;

	localparam logic [2:0] CMD_SYS_WRITE   = 3'd0;
	localparam logic [2:0] CMD_STILE_WRITE = 3'd1;
	localparam logic [2:0] CMD_TILE_WRITE  = 3'd2;
	localparam logic [2:0] CMD_MASK_WRITE  = 3'd3;
	localparam logic [2:0] CMD_QUERY       = 3'd4;

	localparam int SYS_BASE_W    = 13;
	localparam int ATOM_W        = 16;
	localparam int STILE_ENTRY_W = 14;
	localparam int TILE_ENTRY_W  = 15;
	localparam int MASK_W        = 32;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  sys_id;
		logic [15:0] first_atom;
		logic [15:0] second_atom;
		logic [14:0] write_address;
		logic [31:0] write_value;
		logic [15:0] atom_count_value;
	} in_beat_t;

	typedef struct packed {
		logic excluded;
		logic out_of_range;
	} out_beat_t;

endpackage

[design/temlu_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module temlu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/tiled_exclusion_mask_lookup.sv]
// Tiled exclusion mask lookup: one beat per cycle in while query_ready is high; each query
// answer is registered after the last stage. Each command beat walks a six-stage pipeline;
// table writes land at the stage where their table is read, so every command sees all earlier
// writes. Depends on temlu_pkg, temlu_ram and tiled_exclusion_mask_lookup_defines.svh.
//
// A beat is accepted every cycle while the pipeline moves; a bubble anywhere is squeezed out,
// so query_ready drops only when the result register is held and every stage is full. The
// latency is set by the four chained table reads (system table, supertile map, tile map, then
// mask words), each a registered RAM read placed in its own stage, with the divisions by the
// tile lengths done as registered reciprocal multiplies. Tables need no clearing after reset;
// an entry must be written before a query reads it.
`timescale 1ns / 1ps
`include "tiled_exclusion_mask_lookup_defines.svh"

module tiled_exclusion_mask_lookup
	import temlu_pkg::*;
#(
	parameter int STILE_SPAN          = 256,
	parameter int TILE_SPAN           = 16,
	parameter int MAX_SYSTEMS         = 64,
	parameter int SUPERTILE_MAP_DEPTH = 4096,
	parameter int TILE_MAP_DEPTH      = 16384,
	parameter int MASK_DEPTH          = 32768
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      query_valid,
	output logic      query_ready,
	input  in_beat_t  query,
	output logic      result_valid,
	input  logic      result_ready,
	output out_beat_t result
);

	localparam int SYS_AW  = (MAX_SYSTEMS > 1) ? $clog2(MAX_SYSTEMS) : 1;
	localparam int STM_AW  = (SUPERTILE_MAP_DEPTH > 1) ? $clog2(SUPERTILE_MAP_DEPTH) : 1;
	localparam int TLM_AW  = (TILE_MAP_DEPTH > 1) ? $clog2(TILE_MAP_DEPTH) : 1;
	localparam int MSK_AW  = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
	localparam int SYS_W   = ATOM_W + SYS_BASE_W;

	localparam int OFF_W   = $clog2(STILE_SPAN);
	localparam int RI_W    = $clog2(TILE_SPAN);

	localparam int ST_SH       = ATOM_W + OFF_W;
	localparam int ST_RECIP_W  = ATOM_W + 2;
	localparam int ST_PW       = ATOM_W + ST_RECIP_W;
	localparam logic [63:0] ST_RECIP = ((64'd1 << ST_SH) + 64'(STILE_SPAN) - 64'd1)
		/ 64'(STILE_SPAN);
	localparam int STI_MAX     = 65535 / STILE_SPAN;
	localparam int STI_W       = (STI_MAX > 0) ? $clog2(STI_MAX + 1) : 1;

	localparam int NU_W        = ATOM_W + 1;
	localparam int N_SH        = NU_W + OFF_W;
	localparam int N_RECIP_W   = NU_W + 2;
	localparam int N_PW        = NU_W + N_RECIP_W;
	localparam logic [63:0] N_RECIP = ((64'd1 << N_SH) + 64'(STILE_SPAN) - 64'd1)
		/ 64'(STILE_SPAN);
	localparam int NST_MAX     = (65535 + STILE_SPAN - 1) / STILE_SPAN;
	localparam int NST_W       = $clog2(NST_MAX + 1);
	localparam int SN_W        = STI_W + NST_W;
	localparam int ST_IDX_W    = ((SN_W > SYS_BASE_W) ? SN_W : SYS_BASE_W) + 2;

	localparam int T_SH        = OFF_W + RI_W;
	localparam int T_RECIP_W   = OFF_W + 2;
	localparam int T_PW        = OFF_W + T_RECIP_W;
	localparam logic [63:0] T_RECIP = ((64'd1 << T_SH) + 64'(TILE_SPAN) - 64'd1)
		/ 64'(TILE_SPAN);
	localparam int TI_MAX      = (STILE_SPAN - 1) / TILE_SPAN;
	localparam int TI_W        = (TI_MAX > 0) ? $clog2(TI_MAX + 1) : 1;
	localparam int TPS         = STILE_SPAN / TILE_SPAN;
	localparam int TOFF_MAX    = TI_MAX * TPS + TI_MAX;
	localparam int TOFF_W      = (TOFF_MAX > 0) ? $clog2(TOFF_MAX + 1) : 1;
	localparam int T_IDX_W     = ((TOFF_W > STILE_ENTRY_W) ? TOFF_W : STILE_ENTRY_W) + 1;
	localparam int M_IDX_W     = TILE_ENTRY_W + 1;

	// handshake chain
	logic rdy_out, adv1, adv2, adv3, adv4, adv5, adv6, accept;

	// stage 1
	logic             vld_s1, oor_s1;
	logic [2:0]       cmd_s1;
	logic [14:0]      wa_s1;
	logic [31:0]      wv_s1;
	logic [15:0]      ai_s1, aj_s1;
	logic [ST_PW-1:0] pi_s1, pj_s1;
	logic [SYS_W-1:0] sys_rd;

	// stage 2
	logic                  vld_s2, oor_s2;
	logic [2:0]            cmd_s2;
	logic [14:0]           wa_s2;
	logic [31:0]           wv_s2;
	logic [SYS_BASE_W-1:0] base_s2;
	logic [STI_W-1:0]      sti_s2, stj_s2;
	logic [OFF_W-1:0]      offi_s2, offj_s2;
	logic [N_PW-1:0]       pn_s2;

	// stage 3
	logic                  vld_s3, oor_s3;
	logic [2:0]            cmd_s3;
	logic [14:0]           wa_s3;
	logic [31:0]           wv_s3;
	logic [SYS_BASE_W-1:0] base_s3;
	logic [STI_W-1:0]      sti_s3;
	logic [SN_W-1:0]       sn_s3;
	logic [OFF_W-1:0]      offi_s3, offj_s3;
	logic [T_PW-1:0]       pti_s3, ptj_s3;

	// stage 4
	logic                     vld_s4, oor_s4;
	logic [2:0]               cmd_s4;
	logic [14:0]              wa_s4;
	logic [31:0]              wv_s4;
	logic [TOFF_W-1:0]        toff_s4;
	logic [RI_W-1:0]          ri_s4, rj_s4;
	logic [STILE_ENTRY_W-1:0] stile_rd;

	// stage 5
	logic                    vld_s5, oor_s5;
	logic [2:0]              cmd_s5;
	logic [14:0]             wa_s5;
	logic [31:0]             wv_s5;
	logic [RI_W-1:0]         ri_s5, rj_s5;
	logic [TILE_ENTRY_W-1:0] tile_rd;

	// stage 6
	logic              vld_s6, oor_s6;
	logic [2:0]        cmd_s6;
	logic [RI_W-1:0]   rj_s6;
	logic [MASK_W-1:0] mask_rd;

	logic      result_valid_q;
	out_beat_t result_q;

	// stage combinational values
	logic                  sys_oor0;
	logic [ATOM_W-1:0]     natom1;
	logic [SYS_BASE_W-1:0] base1;
	logic [STI_W-1:0]      sti1, stj1;
	logic [15:0]           reml_i1, reml_j1;
	logic [NU_W-1:0]       nup1;
	logic                  atom_oor1;
	logic [NST_W-1:0]      nst2;
	logic [ST_IDX_W-1:0]   st_idx3;
	logic                  st_oor3;
	logic [TI_W-1:0]       ti3, tj3;
	logic [TOFF_W-1:0]     toff3;
	logic [OFF_W:0]        remt_i3, remt_j3;
	logic [T_IDX_W-1:0]    t_idx4;
	logic                  t_oor4;
	logic [M_IDX_W-1:0]    m_idx5;
	logic                  m_oor5;

	logic sys_we, stile_we, tile_we, mask_we;

	assign rdy_out     = !result_valid_q || result_ready;
	assign adv6        = !vld_s6 || rdy_out;
	assign adv5        = !vld_s5 || adv6;
	assign adv4        = !vld_s4 || adv5;
	assign adv3        = !vld_s3 || adv4;
	assign adv2        = !vld_s2 || adv3;
	assign adv1        = !vld_s1 || adv2;
	assign query_ready = adv1;
	assign accept      = query_valid && adv1;

	// stage 0: system table access
	assign sys_oor0 = 32'(query.sys_id) >= 32'(MAX_SYSTEMS);
	assign sys_we   = accept && (query.cmd == CMD_SYS_WRITE) && !sys_oor0;

	temlu_ram #(.WIDTH(SYS_W), .DEPTH(MAX_SYSTEMS)) u_sys_ram (
		.clk   (clk),
		.we    (sys_we),
		.waddr (SYS_AW'(query.sys_id)),
		.wdata ({query.atom_count_value, query.write_value[SYS_BASE_W-1:0]}),
		.re    (adv1),
		.raddr (SYS_AW'(query.sys_id)),
		.rdata (sys_rd)
	);

	// stage 1: atom bounds, supertile coordinates
	assign natom1    = sys_rd[SYS_BASE_W +: ATOM_W];
	assign base1     = sys_rd[SYS_BASE_W-1:0];
	assign sti1      = pi_s1[ST_SH +: STI_W];
	assign stj1      = pj_s1[ST_SH +: STI_W];
	assign reml_i1   = ai_s1 - 16'(sti1) * 16'(STILE_SPAN);
	assign reml_j1   = aj_s1 - 16'(stj1) * 16'(STILE_SPAN);
	assign nup1      = NU_W'(natom1) + NU_W'(STILE_SPAN - 1);
	assign atom_oor1 = (ai_s1 >= natom1) || (aj_s1 >= natom1);

	// stage 2: supertiles per side
	assign nst2 = pn_s2[N_SH +: NST_W];

	// stage 3: supertile address, tile coordinates
	assign st_idx3 = ST_IDX_W'(base_s3) + ST_IDX_W'(sn_s3) + ST_IDX_W'(sti_s3);
	assign st_oor3 = 32'(st_idx3) >= 32'(SUPERTILE_MAP_DEPTH);
	assign ti3     = pti_s3[T_SH +: TI_W];
	assign tj3     = ptj_s3[T_SH +: TI_W];
	assign toff3   = TOFF_W'(tj3) * TOFF_W'(TPS) + TOFF_W'(ti3);
	assign remt_i3 = (OFF_W + 1)'(offi_s3) - (OFF_W + 1)'(ti3) * (OFF_W + 1)'(TILE_SPAN);
	assign remt_j3 = (OFF_W + 1)'(offj_s3) - (OFF_W + 1)'(tj3) * (OFF_W + 1)'(TILE_SPAN);

	assign stile_we = adv4 && vld_s3 && (cmd_s3 == CMD_STILE_WRITE)
		&& (32'(wa_s3) < 32'(SUPERTILE_MAP_DEPTH));

	temlu_ram #(.WIDTH(STILE_ENTRY_W), .DEPTH(SUPERTILE_MAP_DEPTH)) u_stile_ram (
		.clk   (clk),
		.we    (stile_we),
		.waddr (STM_AW'(wa_s3)),
		.wdata (wv_s3[STILE_ENTRY_W-1:0]),
		.re    (adv4),
		.raddr (STM_AW'(st_idx3)),
		.rdata (stile_rd)
	);

	// stage 4: tile map address
	assign t_idx4 = T_IDX_W'(stile_rd) + T_IDX_W'(toff_s4);
	assign t_oor4 = 32'(t_idx4) >= 32'(TILE_MAP_DEPTH);

	assign tile_we = adv5 && vld_s4 && (cmd_s4 == CMD_TILE_WRITE)
		&& (32'(wa_s4) < 32'(TILE_MAP_DEPTH));

	temlu_ram #(.WIDTH(TILE_ENTRY_W), .DEPTH(TILE_MAP_DEPTH)) u_tile_ram (
		.clk   (clk),
		.we    (tile_we),
		.waddr (TLM_AW'(wa_s4)),
		.wdata (wv_s4[TILE_ENTRY_W-1:0]),
		.re    (adv5),
		.raddr (TLM_AW'(t_idx4)),
		.rdata (tile_rd)
	);

	// stage 5: mask word address
	assign m_idx5 = M_IDX_W'(tile_rd) + M_IDX_W'(ri_s5);
	assign m_oor5 = 32'(m_idx5) >= 32'(MASK_DEPTH);

	assign mask_we = adv6 && vld_s5 && (cmd_s5 == CMD_MASK_WRITE)
		&& (32'(wa_s5) < 32'(MASK_DEPTH));

	temlu_ram #(.WIDTH(MASK_W), .DEPTH(MASK_DEPTH)) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (MSK_AW'(wa_s5)),
		.wdata (wv_s5),
		.re    (adv6),
		.raddr (MSK_AW'(m_idx5)),
		.rdata (mask_rd)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			vld_s4         <= 1'b0;
			vld_s5         <= 1'b0;
			vld_s6         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= query_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
			if (adv4) begin
				vld_s4 <= vld_s3;
			end
			if (adv5) begin
				vld_s5 <= vld_s4;
			end
			if (adv6) begin
				vld_s6 <= vld_s5;
			end
			if (rdy_out) begin
				result_valid_q <= vld_s6 && (cmd_s6 == CMD_QUERY);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1 <= query.cmd;
			wa_s1  <= query.write_address;
			wv_s1  <= query.write_value;
			ai_s1  <= query.first_atom;
			aj_s1  <= query.second_atom;
			pi_s1  <= ST_PW'(query.first_atom) * ST_PW'(ST_RECIP[ST_RECIP_W-1:0]);
			pj_s1  <= ST_PW'(query.second_atom) * ST_PW'(ST_RECIP[ST_RECIP_W-1:0]);
			oor_s1 <= sys_oor0;
		end
		if (adv2) begin
			cmd_s2  <= cmd_s1;
			wa_s2   <= wa_s1;
			wv_s2   <= wv_s1;
			base_s2 <= base1;
			sti_s2  <= sti1;
			stj_s2  <= stj1;
			offi_s2 <= reml_i1[OFF_W-1:0];
			offj_s2 <= reml_j1[OFF_W-1:0];
			pn_s2   <= N_PW'(nup1) * N_PW'(N_RECIP[N_RECIP_W-1:0]);
			oor_s2  <= oor_s1 || atom_oor1;
		end
		if (adv3) begin
			cmd_s3  <= cmd_s2;
			wa_s3   <= wa_s2;
			wv_s3   <= wv_s2;
			base_s3 <= base_s2;
			sti_s3  <= sti_s2;
			sn_s3   <= SN_W'(stj_s2) * SN_W'(nst2);
			offi_s3 <= offi_s2;
			offj_s3 <= offj_s2;
			pti_s3  <= T_PW'(offi_s2) * T_PW'(T_RECIP[T_RECIP_W-1:0]);
			ptj_s3  <= T_PW'(offj_s2) * T_PW'(T_RECIP[T_RECIP_W-1:0]);
			oor_s3  <= oor_s2;
		end
		if (adv4) begin
			cmd_s4  <= cmd_s3;
			wa_s4   <= wa_s3;
			wv_s4   <= wv_s3;
			toff_s4 <= toff3;
			ri_s4   <= remt_i3[RI_W-1:0];
			rj_s4   <= remt_j3[RI_W-1:0];
			oor_s4  <= oor_s3 || st_oor3;
		end
		if (adv5) begin
			cmd_s5 <= cmd_s4;
			wa_s5  <= wa_s4;
			wv_s5  <= wv_s4;
			ri_s5  <= ri_s4;
			rj_s5  <= rj_s4;
			oor_s5 <= oor_s4 || t_oor4;
		end
		if (adv6) begin
			cmd_s6 <= cmd_s5;
			rj_s6  <= rj_s5;
			oor_s6 <= oor_s5 || m_oor5;
		end
		if (rdy_out) begin
			result_q.excluded     <= !oor_s6 && mask_rd[5'(rj_s6)];
			result_q.out_of_range <= oor_s6;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TEMLU_ASSERT_NOW(a_free_slot_ready, clk, arst_n, !result_valid_q, query_ready,
		"input stalled while result register is empty")
	`TEMLU_ASSERT_NOW(a_fault_clears_bit, clk, arst_n, result_valid_q,
		!(result_q.excluded && result_q.out_of_range), "excluded raised on a faulted query")
	`TEMLU_ASSERT_NEXT(a_query_delivered, clk, arst_n,
		vld_s6 && (cmd_s6 == CMD_QUERY) && rdy_out, result_valid_q,
		"query leaving the last stage did not reach the result register")

endmodule

[bench/tb_tiled_exclusion_mask_lookup.sv]
`timescale 1ns / 1ps
// Self-checking bench for tiled_exclusion_mask_lookup: a directed table, then random table
// loads and pair queries checked against a shadow copy of the lookup tables.
// Depends on temlu_pkg and the block's RTL.

module tb_tiled_exclusion_mask_lookup;
	import temlu_pkg::*;

	localparam int ST_LEN   = 256;
	localparam int T_LEN    = 16;
	localparam int N_SYS    = 64;
	localparam int ST_DEPTH = 4096;
	localparam int T_DEPTH  = 16384;
	localparam int M_DEPTH  = 32768;
	localparam int ITEMS    = 1100;

	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t answer;
	} step_t;

	logic      clk;
	logic      arst_n;
	logic      query_valid;
	logic      query_ready;
	in_beat_t  query;
	logic      result_valid;
	logic      result_ready;
	out_beat_t result;

	logic [SYS_BASE_W-1:0]    sys_base_img  [N_SYS];
	logic [ATOM_W-1:0]        sys_atoms_img [N_SYS];
	logic [STILE_ENTRY_W-1:0] stile_img     [ST_DEPTH];
	logic [TILE_ENTRY_W-1:0]  tile_img      [T_DEPTH];
	logic [MASK_W-1:0]        mask_img      [M_DEPTH];
	bit sys_loaded   [N_SYS];
	bit stile_loaded [ST_DEPTH];
	bit tile_loaded  [T_DEPTH];
	bit mask_loaded  [M_DEPTH];

	out_beat_t answers_due[$];
	int        fault_count = 0;
	int        n_items = 0;
	bit        calm = 1'b0;
	bit        want_hold = 1'b0;

	tiled_exclusion_mask_lookup #(
		.STILE_SPAN         (ST_LEN),
		.TILE_SPAN          (T_LEN),
		.MAX_SYSTEMS        (N_SYS),
		.SUPERTILE_MAP_DEPTH(ST_DEPTH),
		.TILE_MAP_DEPTH     (T_DEPTH),
		.MASK_DEPTH         (M_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_tiled_exclusion_mask_lookup: errors");
		$finish;
	end

	task automatic mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fault_count++;
	endtask

	function automatic in_beat_t noise();
		logic [127:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		return raw[$bits(in_beat_t)-1:0];
	endfunction

	function automatic step_t row(input logic [2:0] c, input logic [5:0] s,
			input logic [15:0] ai, input logic [15:0] aj, input logic [14:0] a,
			input logic [31:0] v, input logic [15:0] n, input bit oor_row = 1'b0);
		step_t r;
		r.beat = '{cmd: c, sys_id: s, first_atom: ai, second_atom: aj,
			write_address: a, write_value: v, atom_count_value: n};
		r.typed = oor_row;
		r.answer = '{excluded: 1'b0, out_of_range: 1'b1};
		return r;
	endfunction

	// Walk the four table levels; return the command that must load a missing entry
	// (its index in slot), or CMD_QUERY when the answer is complete.
	function automatic logic [2:0] lookup_exclusion(input in_beat_t b, output out_beat_t ans,
			output int unsigned slot);
		int unsigned natom, nst, ai, aj, st_idx, t_idx, m_idx;
		ans = '{excluded: 1'b0, out_of_range: 1'b1};
		slot = 32'(b.sys_id);
		if (!sys_loaded[b.sys_id])
			return CMD_SYS_WRITE;
		natom = 32'(sys_atoms_img[b.sys_id]);
		ai = 32'(b.first_atom);
		aj = 32'(b.second_atom);
		if (ai >= natom || aj >= natom)
			return CMD_QUERY;
		nst = (natom + ST_LEN - 1) / ST_LEN;
		st_idx = 32'(sys_base_img[b.sys_id]) + (aj / ST_LEN) * nst + ai / ST_LEN;
		if (st_idx >= ST_DEPTH)
			return CMD_QUERY;
		slot = st_idx;
		if (!stile_loaded[st_idx])
			return CMD_STILE_WRITE;
		t_idx = 32'(stile_img[st_idx]) + ((aj % ST_LEN) / T_LEN) * (ST_LEN / T_LEN)
			+ (ai % ST_LEN) / T_LEN;
		if (t_idx >= T_DEPTH)
			return CMD_QUERY;
		slot = t_idx;
		if (!tile_loaded[t_idx])
			return CMD_TILE_WRITE;
		m_idx = 32'(tile_img[t_idx]) + (ai % ST_LEN) % T_LEN;
		if (m_idx >= M_DEPTH)
			return CMD_QUERY;
		slot = m_idx;
		if (!mask_loaded[m_idx])
			return CMD_MASK_WRITE;
		ans.out_of_range = 1'b0;
		ans.excluded = mask_img[m_idx][5'((aj % ST_LEN) % T_LEN)];
		return CMD_QUERY;
	endfunction

	task automatic send_cmd(input in_beat_t b, input bit typed = 1'b0,
			input out_beat_t given = '0);
		out_beat_t   ans;
		int unsigned slot;
		while (!calm && $urandom_range(99) < 26) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= b;
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
		case (b.cmd)
			CMD_SYS_WRITE: begin
				sys_base_img[b.sys_id] = b.write_value[SYS_BASE_W-1:0];
				sys_atoms_img[b.sys_id] = b.atom_count_value;
				sys_loaded[b.sys_id] = 1'b1;
				n_items++;
			end
			CMD_STILE_WRITE: if (b.write_address < ST_DEPTH) begin
				stile_img[b.write_address] = b.write_value[STILE_ENTRY_W-1:0];
				stile_loaded[b.write_address] = 1'b1;
				n_items++;
			end
			CMD_TILE_WRITE: if (b.write_address < T_DEPTH) begin
				tile_img[b.write_address] = b.write_value[TILE_ENTRY_W-1:0];
				tile_loaded[b.write_address] = 1'b1;
				n_items++;
			end
			CMD_MASK_WRITE: if (b.write_address < M_DEPTH) begin
				mask_img[b.write_address] = b.write_value;
				mask_loaded[b.write_address] = 1'b1;
				n_items++;
			end
			CMD_QUERY: begin
				if (lookup_exclusion(b, ans, slot) != CMD_QUERY)
					mismatch("query would read an unloaded table entry");
				answers_due.push_back(typed ? given : ans);
				n_items++;
			end
			default: ;
		endcase
	endtask

	// Load every entry the query's path still lacks, then send the query.
	task automatic query_with_tables(input in_beat_t q);
		in_beat_t    w;
		out_beat_t   ans;
		int unsigned slot, top;
		logic [2:0]  need;
		top = (q.first_atom > q.second_atom) ? 32'(q.first_atom) : 32'(q.second_atom);
		need = lookup_exclusion(q, ans, slot);
		while (need != CMD_QUERY) begin
			w = noise();
			w.cmd = need;
			if (need == CMD_SYS_WRITE) begin
				w.sys_id = 6'(slot);
				if ($urandom_range(99) < 85)
					w.write_value[SYS_BASE_W-1:0] = SYS_BASE_W'($urandom_range(0, 3000));
				if ($urandom_range(99) < 75)
					w.atom_count_value = 16'(top + 1 + $urandom_range(0, 200));
			end else begin
				w.write_address = 15'(slot);
			end
			send_cmd(w);
			need = lookup_exclusion(q, ans, slot);
		end
		send_cmd(q);
	endtask

	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				result_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			result_ready <= calm || $urandom_range(99) >= 26;
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (answers_due.size() == 0) begin
				mismatch("result beat with no query outstanding");
			end else begin
				want = answers_due.pop_front();
				if (result.excluded !== want.excluded)
					mismatch($sformatf("excluded %b, want %b", result.excluded,
						want.excluded));
				if (result.out_of_range !== want.out_of_range)
					mismatch($sformatf("out_of_range %b, want %b", result.out_of_range,
						want.out_of_range));
			end
		end
	end

	initial begin
		step_t    plan [26];
		in_beat_t w;
		int       k, span;
		bit       held, drained;
		held = 1'b0;
		drained = 1'b0;
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		plan = '{
			row(CMD_SYS_WRITE,   6'd0,  16'd0,      16'd0,      15'd0,     32'd0,         16'd32),
			row(CMD_QUERY,       6'd0,  16'd32,     16'd0,      15'd0,     32'd0,         16'd0, 1),
			row(CMD_QUERY,       6'd0,  16'd0,      16'hFFFF,   15'd0,     32'd0,         16'd0, 1),
			row(CMD_STILE_WRITE, 6'd0,  16'd0,      16'd0,      15'd0,     32'hFFFF_C010, 16'd0),
			row(CMD_TILE_WRITE,  6'd0,  16'd0,      16'd0,      15'd32,    32'hFFFF_8040, 16'd0),
			row(CMD_MASK_WRITE,  6'd0,  16'd0,      16'd0,      15'd69,    32'h0000_0010, 16'd0),
			row(CMD_QUERY,       6'd0,  16'd5,      16'd20,     15'd0,     32'd0,         16'd0),
			row(CMD_QUERY,       6'd0,  16'd5,      16'd21,     15'd0,     32'd0,         16'd0),
			row(CMD_MASK_WRITE,  6'd0,  16'd0,      16'd0,      15'h7FFF,  32'hFFFF_FFFF, 16'd0),
			row(CMD_STILE_WRITE, 6'd0,  16'd0,      16'd0,      15'h7FFF,  32'd0,         16'd0),
			row(CMD_TILE_WRITE,  6'd0,  16'd0,      16'd0,      15'd16384, 32'd0,         16'd0),
			row(3'd5,            6'h3F, 16'hFFFF,   16'hFFFF,   15'h7FFF,  32'hFFFF_FFFF, 16'hFFFF),
			row(3'd6,            6'h3F, 16'hFFFF,   16'hFFFF,   15'h7FFF,  32'hFFFF_FFFF, 16'hFFFF),
			row(3'd7,            6'h3F, 16'hFFFF,   16'hFFFF,   15'h7FFF,  32'hFFFF_FFFF, 16'hFFFF),
			row(CMD_SYS_WRITE,   6'd63, 16'd0,      16'd0,      15'd0,     32'hFFFF_FFFF, 16'hFFFF),
			row(CMD_QUERY,       6'd63, 16'd0,      16'd0,      15'd0,     32'd0,         16'd0, 1),
			row(CMD_QUERY,       6'd63, 16'hFFFF,   16'hFFFF,   15'd0,     32'd0,         16'd0, 1),
			row(CMD_SYS_WRITE,   6'd1,  16'd0,      16'd0,      15'd0,     32'd100,       16'd256),
			row(CMD_STILE_WRITE, 6'd0,  16'd0,      16'd0,      15'd100,   32'h0000_3FFF, 16'd0),
			row(CMD_QUERY,       6'd1,  16'd16,     16'd0,      15'd0,     32'd0,         16'd0, 1),
			row(CMD_TILE_WRITE,  6'd0,  16'd0,      16'd0,      15'd16383, 32'h0000_7FFF, 16'd0),
			row(CMD_QUERY,       6'd1,  16'd1,      16'd0,      15'd0,     32'd0,         16'd0, 1),
			row(CMD_QUERY,       6'd1,  16'd0,      16'd0,      15'd0,     32'd0,         16'd0),
			row(CMD_QUERY,       6'd1,  16'd0,      16'd15,     15'd0,     32'd0,         16'd0),
			row(CMD_SYS_WRITE,   6'd2,  16'd0,      16'd0,      15'd0,     32'd0,         16'd0),
			row(CMD_QUERY,       6'd2,  16'd0,      16'd0,      15'd0,     32'd0,         16'd0, 1)
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_cmd(plan[i].beat, plan[i].typed, plan[i].answer);

		while (n_items < ITEMS) begin
			calm = (n_items >= 350 && n_items < 550);
			if (!held && n_items >= 200) begin
				held = 1'b1;
				want_hold = 1'b1;
			end
			if (!drained && n_items >= 700) begin
				drained = 1'b1;
				query_valid <= 1'b0;
				@(posedge clk);
				while (answers_due.size() != 0)
					@(posedge clk);
			end
			k = $urandom_range(99);
			w = noise();
			if (k < 8) begin
				w.cmd = CMD_SYS_WRITE;
				w.sys_id = 6'($urandom_range(0, 7));
				if ($urandom_range(99) < 85)
					w.write_value[SYS_BASE_W-1:0] = SYS_BASE_W'($urandom_range(0, 3000));
				k = $urandom_range(99);
				if (k < 70)
					w.atom_count_value = 16'($urandom_range(1, 700));
				else if (k < 80)
					w.atom_count_value = '0;
				send_cmd(w);
			end else if (k < 16) begin
				w.cmd = 3'($urandom_range(CMD_STILE_WRITE, CMD_MASK_WRITE));
				if ($urandom_range(1) == 1)
					w.write_address = 15'($urandom_range(0, ST_DEPTH - 1));
				send_cmd(w);
			end else if (k < 20) begin
				while (w.cmd <= CMD_QUERY)
					w = noise();
				send_cmd(w);
			end else begin
				w.cmd = CMD_QUERY;
				if (k >= 32) begin
					if ($urandom_range(99) < 80)
						w.sys_id = 6'($urandom_range(0, 7));
					if (sys_loaded[w.sys_id] && sys_atoms_img[w.sys_id] != 0) begin
						span = int'(sys_atoms_img[w.sys_id]);
						if ($urandom_range(1) == 1 && span > 48)
							span = 48;
						if ($urandom_range(99) < 90) begin
							w.first_atom = 16'($urandom_range(0, span - 1));
							w.second_atom = 16'($urandom_range(0, span - 1));
						end
					end else begin
						w.first_atom = 16'($urandom_range(0, 300));
						w.second_atom = 16'($urandom_range(0, 300));
					end
				end
				query_with_tables(w);
			end
		end

		calm = 1'b0;
		query_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("tb_tiled_exclusion_mask_lookup: clean");
		else
			$display("tb_tiled_exclusion_mask_lookup: errors");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/temlu_pkg.sv
design/temlu_ram.sv
design/tiled_exclusion_mask_lookup.sv
bench/tb_tiled_exclusion_mask_lookup.sv
